/* rtl/core/sjs_pkg.sv */
// shared types and constants for the stepper jog and sweep sequencer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sjs_pkg;

	localparam int TIMER_BITS = 16;

	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;

	localparam int TAP_BITS   = 6;
	localparam int SWEEP_BITS = 8;
	localparam int COIL_BITS  = 4;
	localparam int PHASE_BITS = 2;
	localparam int WIN_BITS   = 16;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [COIL_BITS-1:0]  coil_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TAPS_TO_SWEEP  = 8'd0,
		REG_SWEEP_LENGTH   = 8'd1,
		REG_TAP_WINDOW_MS  = 8'd2,
		REG_STEP_PERIOD_MS = 8'd3
	} cfg_reg_t;

	localparam logic [TAP_BITS-1:0]   TAPS_TO_SWEEP_RST  = 6'd3;
	localparam logic [SWEEP_BITS-1:0] SWEEP_LENGTH_RST   = 8'd100;
	localparam logic [WIN_BITS-1:0]   TAP_WINDOW_MS_RST  = 16'd500;
	localparam logic [WIN_BITS-1:0]   STEP_PERIOD_MS_RST = 16'd10;

	// coil drive per phase: 8,1,4,2 walking clockwise
	function automatic coil_t coil_of_phase(input logic [PHASE_BITS-1:0] ph);
		coil_t c;
		case (ph)
			2'd0: c = 4'h8;
			2'd1: c = 4'h1;
			2'd2: c = 4'h4;
			2'd3: c = 4'h2;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sjs_ifs.sv */
// valid/ready channels of the sequencer: poll requests, results, config writes
// depends on sjs_pkg for field widths
`default_nettype none

interface sjs_poll_if;
	logic valid;
	logic ready;
	logic cw_key;
	logic ccw_key;
	logic tick;
	modport source (output valid, cw_key, ccw_key, tick, input ready);
	modport sink (input valid, cw_key, ccw_key, tick, output ready);
endinterface

interface sjs_result_if;
	logic              valid;
	logic              ready;
	sjs_pkg::coil_t    coil_pattern;
	logic              step_taken;
	logic              turning_ccw;
	logic              sweeping;
	modport source (output valid, coil_pattern, step_taken, turning_ccw, sweeping,
		input ready);
	modport sink (input valid, coil_pattern, step_taken, turning_ccw, sweeping,
		output ready);
endinterface

interface sjs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sjs_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [sjs_pkg::CFG_DATA_BITS-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/stepper_jog_and_sweep_sequencer_top.sv */
// stepper jog and sweep sequencer, top level
// depends on sjs_pkg and the channel interfaces in sjs_ifs.sv
`default_nettype none

// One poll request is taken per clock and its result appears in the output
// register in the next cycle; the only stall is a result that has not been taken,
// since the whole state update is one combinational pass from the held state and
// the request into the state and result registers. Config writes are always
// ready and must only be issued while no request is in flight.
module stepper_jog_and_sweep_sequencer_top (
	input  wire              clk,
	input  wire              arst_n,
	sjs_cfg_if.sink          cfg,
	sjs_poll_if.sink         poll,
	sjs_result_if.source     result
);

	logic [sjs_pkg::TAP_BITS-1:0]   taps_to_sweep_q;
	logic [sjs_pkg::SWEEP_BITS-1:0] sweep_length_q;
	logic [sjs_pkg::WIN_BITS-1:0]   tap_window_q;
	logic [sjs_pkg::WIN_BITS-1:0]   step_period_q;

	logic                           key_held_q;
	logic [sjs_pkg::TAP_BITS-1:0]   tap_count_q;
	logic                           dir_q;
	logic [sjs_pkg::SWEEP_BITS-1:0] sweep_done_q;
	logic [sjs_pkg::PHASE_BITS-1:0] phase_q;
	sjs_pkg::timer_t                tap_timer_q;
	sjs_pkg::timer_t                step_timer_q;
	sjs_pkg::coil_t                 coils_q;

	logic res_valid_q;
	logic res_step_q;
	logic res_sweep_q;

	logic                           key_held_d;
	logic [sjs_pkg::TAP_BITS-1:0]   tap_count_d;
	logic                           dir_d;
	logic [sjs_pkg::SWEEP_BITS-1:0] sweep_done_d;
	logic [sjs_pkg::PHASE_BITS-1:0] phase_d;
	sjs_pkg::timer_t                tap_timer_d;
	sjs_pkg::timer_t                step_timer_d;
	sjs_pkg::coil_t                 coils_d;
	logic                           step_d;
	logic                           pressed;
	logic                           poll_acc;

	assign cfg.ready  = 1'b1;
	assign poll.ready = !res_valid_q || result.ready;
	assign poll_acc   = poll.valid && poll.ready;
	assign pressed    = poll.cw_key || poll.ccw_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_to_sweep_q <= sjs_pkg::TAPS_TO_SWEEP_RST;
			sweep_length_q  <= sjs_pkg::SWEEP_LENGTH_RST;
			tap_window_q    <= sjs_pkg::TAP_WINDOW_MS_RST;
			step_period_q   <= sjs_pkg::STEP_PERIOD_MS_RST;
		end else if (cfg.valid) begin
			case (sjs_pkg::cfg_reg_t'(cfg.index))
				sjs_pkg::REG_TAPS_TO_SWEEP:
					taps_to_sweep_q <= cfg.data[sjs_pkg::TAP_BITS-1:0];
				sjs_pkg::REG_SWEEP_LENGTH:
					sweep_length_q <= cfg.data[sjs_pkg::SWEEP_BITS-1:0];
				sjs_pkg::REG_TAP_WINDOW_MS:
					tap_window_q <= cfg.data[sjs_pkg::WIN_BITS-1:0];
				sjs_pkg::REG_STEP_PERIOD_MS:
					step_period_q <= cfg.data[sjs_pkg::WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		key_held_d   = key_held_q;
		tap_count_d  = tap_count_q;
		dir_d        = dir_q;
		sweep_done_d = sweep_done_q;
		phase_d      = phase_q;
		tap_timer_d  = tap_timer_q;
		step_timer_d = step_timer_q;
		coils_d      = coils_q;
		step_d       = 1'b0;

		// tick is applied first, timers stop at zero
		if (poll.tick && tap_timer_d != '0)
			tap_timer_d = tap_timer_d - 1'b1;
		if (poll.tick && step_timer_d != '0)
			step_timer_d = step_timer_d - 1'b1;

		// tap counting
		if (tap_timer_d != '0 || pressed) begin
			if (pressed && !key_held_d) begin
				tap_timer_d = sjs_pkg::timer_t'(tap_window_q);
				key_held_d  = 1'b1;
			end
			if (!pressed && key_held_d) begin
				key_held_d  = 1'b0;
				tap_count_d = tap_count_d + 1'b1;
				if (tap_count_d >= taps_to_sweep_q) begin
					dir_d        = 1'b0;
					sweep_done_d = '0;
				end
			end
		end else begin
			key_held_d = 1'b0;
			if (tap_count_d < taps_to_sweep_q)
				tap_count_d = '0;
		end

		// stepping
		if (step_timer_d == '0 && (pressed || tap_count_d >= taps_to_sweep_q)) begin
			// a tap past the threshold stops the sweep
			if (tap_count_d > taps_to_sweep_q)
				tap_count_d = '0;
			if (poll.cw_key)
				dir_d = 1'b0;
			else if (poll.ccw_key)
				dir_d = 1'b1;
			if (tap_count_d >= taps_to_sweep_q) begin
				if (sweep_done_d > sweep_length_q) begin
					dir_d        = !dir_d;
					sweep_done_d = '0;
				end
				sweep_done_d = sweep_done_d + 1'b1;
			end
			step_timer_d = sjs_pkg::timer_t'(step_period_q);
			coils_d      = sjs_pkg::coil_of_phase(phase_d);
			phase_d      = dir_d ? phase_d - 1'b1 : phase_d + 1'b1;
			step_d       = 1'b1;
		end else if (!pressed && tap_count_d == '0) begin
			sweep_done_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q   <= 1'b0;
			tap_count_q  <= '0;
			dir_q        <= 1'b0;
			sweep_done_q <= '0;
			phase_q      <= '0;
			tap_timer_q  <= '0;
			step_timer_q <= '0;
			coils_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (poll_acc) begin
				key_held_q   <= key_held_d;
				tap_count_q  <= tap_count_d;
				dir_q        <= dir_d;
				sweep_done_q <= sweep_done_d;
				phase_q      <= phase_d;
				tap_timer_q  <= tap_timer_d;
				step_timer_q <= step_timer_d;
				coils_q      <= coils_d;
				res_valid_q  <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_acc) begin
			res_step_q  <= step_d;
			res_sweep_q <= tap_count_d >= taps_to_sweep_q;
		end
	end

	// coils and direction only move on an accepted request, so they are the result
	assign result.valid        = res_valid_q;
	assign result.coil_pattern = coils_q;
	assign result.turning_ccw  = dir_q;
	assign result.step_taken   = res_step_q;
	assign result.sweeping     = res_sweep_q;

	a_step_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_step_q |-> $onehot(coils_q))
		else $error("step result without a one-hot coil pattern");

	a_coils_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(coils_q))
		else $error("more than one coil energized");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		poll_acc |=> res_valid_q)
		else $error("accepted request produced no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |-> !poll.ready)
		else $error("request taken while result stalled");

	a_timer_loaded_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		poll_acc && step_d |=> step_timer_q == sjs_pkg::timer_t'($past(step_period_q)))
		else $error("step timer not reloaded after a step");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking bench for the stepper jog and sweep sequencer top level
// needs sjs_pkg, the channel interfaces in sjs_ifs.sv and the top level
`timescale 1ns / 1ps

module tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef logic [sjs_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

	typedef struct packed {
		logic cw;
		logic ccw;
		logic tick;
	} poll_t;

	typedef struct packed {
		sjs_pkg::coil_t coils;
		logic           stepped;
		logic           ccw;
		logic           sweeping;
	} drive_t;

	// coil drive for each phase, walking clockwise
	localparam sjs_pkg::coil_t PHASE_COIL [4] = '{4'h8, 4'h1, 4'h4, 4'h2};

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	sjs_cfg_if    cfg_ch ();
	sjs_poll_if   poll_ch ();
	sjs_result_if result_ch ();

	stepper_jog_and_sweep_sequencer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.poll   (poll_ch),
		.result (result_ch)
	);

	always #10 clk = ~clk;

	// predicted sequencer state and register copy
	logic                           key_down;
	logic [sjs_pkg::TAP_BITS-1:0]   tap_cnt;
	logic                           dir_ccw;
	logic [sjs_pkg::SWEEP_BITS-1:0] sweep_cnt;
	logic [sjs_pkg::PHASE_BITS-1:0] coil_phase;
	sjs_pkg::timer_t                tap_tmr;
	sjs_pkg::timer_t                step_tmr;
	sjs_pkg::coil_t                 coil_now;
	logic [sjs_pkg::TAP_BITS-1:0]   thr_taps;
	logic [sjs_pkg::SWEEP_BITS-1:0] sweep_len;
	logic [sjs_pkg::WIN_BITS-1:0]   tap_window;
	logic [sjs_pkg::WIN_BITS-1:0]   step_period;

	poll_t  poll_q [$];
	drive_t drive_q [$];
	int     polls_queued = 0;
	int     drives_seen = 0;
	int     errors = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_req = 0;
	int     hold_ack = 0;
	int     hold_left = 0;
	int     quiet = 0;
	poll_t  drv_item;
	drive_t want;

	function automatic drive_t advance_sequencer(input poll_t p);
		logic   pressed;
		drive_t r;
		pressed = p.cw | p.ccw;
		r.stepped = 1'b0;
		if (p.tick) begin
			if (tap_tmr != 0) tap_tmr = tap_tmr - 1'b1;
			if (step_tmr != 0) step_tmr = step_tmr - 1'b1;
		end
		if (tap_tmr != 0 || pressed) begin
			if (pressed && !key_down) begin
				tap_tmr = sjs_pkg::timer_t'(tap_window);
				key_down = 1'b1;
			end
			if (!pressed && key_down) begin
				key_down = 1'b0;
				tap_cnt = tap_cnt + 1'b1;
				if (tap_cnt >= thr_taps) begin
					dir_ccw = 1'b0;
					sweep_cnt = '0;
				end
			end
		end else begin
			// window closed with nothing held: short tap runs are dropped
			key_down = 1'b0;
			if (tap_cnt < thr_taps) tap_cnt = '0;
		end
		if (step_tmr == 0 && (pressed || tap_cnt >= thr_taps)) begin
			// one tap past the threshold ends the sweep on the next step
			if (tap_cnt > thr_taps) tap_cnt = '0;
			if (p.cw) dir_ccw = 1'b0;
			else if (p.ccw) dir_ccw = 1'b1;
			if (tap_cnt >= thr_taps) begin
				if (sweep_cnt > sweep_len) begin
					dir_ccw = ~dir_ccw;
					sweep_cnt = '0;
				end
				sweep_cnt = sweep_cnt + 1'b1;
			end
			step_tmr = sjs_pkg::timer_t'(step_period);
			coil_now = PHASE_COIL[coil_phase];
			coil_phase = dir_ccw ? coil_phase - 1'b1 : coil_phase + 1'b1;
			r.stepped = 1'b1;
		end else if (!pressed && tap_cnt == 0) begin
			sweep_cnt = '0;
		end
		r.coils = coil_now;
		r.ccw = dir_ccw;
		r.sweeping = (tap_cnt >= thr_taps);
		return r;
	endfunction

	// poll driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_ch.valid <= 1'b0;
			poll_ch.cw_key <= 1'b0;
			poll_ch.ccw_key <= 1'b0;
			poll_ch.tick <= 1'b0;
		end else if (!poll_ch.valid || poll_ch.ready) begin
			if (poll_ch.valid)
				drive_q.push_back(advance_sequencer({poll_ch.cw_key, poll_ch.ccw_key,
					poll_ch.tick}));
			if (poll_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_item = poll_q.pop_front();
				poll_ch.valid <= 1'b1;
				poll_ch.cw_key <= drv_item.cw;
				poll_ch.ccw_key <= drv_item.ccw;
				poll_ch.tick <= drv_item.tick;
			end else begin
				poll_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (drive_q.size() == 0) begin
					$error("result with no poll waiting for it");
					errors++;
				end else begin
					want = drive_q.pop_front();
					if (result_ch.coil_pattern !== want.coils) begin
						$error("coil_pattern: expected %h, got %h", want.coils,
							result_ch.coil_pattern);
						errors++;
					end
					if (result_ch.step_taken !== want.stepped) begin
						$error("step_taken: expected %b, got %b", want.stepped,
							result_ch.step_taken);
						errors++;
					end
					if (result_ch.turning_ccw !== want.ccw) begin
						$error("turning_ccw: expected %b, got %b", want.ccw,
							result_ch.turning_ccw);
						errors++;
					end
					if (result_ch.sweeping !== want.sweeping) begin
						$error("sweeping: expected %b, got %b", want.sweeping,
							result_ch.sweeping);
						errors++;
					end
					drives_seen++;
				end
			end
			// long hold-off so the block backs up into the poll channel
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic add_poll(input logic cw, input logic ccw, input logic tick);
		poll_t p;
		p.cw = cw;
		p.ccw = ccw;
		p.tick = tick;
		poll_q.push_back(p);
		polls_queued++;
	endtask

	// mostly taps and holds with random buttons and ticks, some idling and noise
	task automatic add_moves(input int n);
		int         first;
		int         kind;
		logic [1:0] keys;
		first = polls_queued;
		while (polls_queued - first < n) begin
			kind = $urandom_range(0, 9);
			keys = 2'($urandom_range(1, 3));
			if (kind < 4) begin
				repeat ($urandom_range(1, 3)) add_poll(keys[1], keys[0], 1'($urandom_range(0, 1)));
				repeat ($urandom_range(1, 3)) add_poll(1'b0, 1'b0, 1'($urandom_range(0, 1)));
			end else if (kind < 6) begin
				repeat ($urandom_range(4, 20))
					add_poll(keys[1], keys[0], $urandom_range(0, 3) != 0);
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 30)) add_poll(1'b0, 1'b0, $urandom_range(0, 4) != 0);
			end else begin
				repeat ($urandom_range(1, 5))
					add_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic wait_drained();
		while (drives_seen != polls_queued) @(posedge clk);
	endtask

	task automatic write_reg(input sjs_pkg::cfg_reg_t idx, input cfg_data_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			sjs_pkg::REG_TAPS_TO_SWEEP:  thr_taps = val[sjs_pkg::TAP_BITS-1:0];
			sjs_pkg::REG_SWEEP_LENGTH:   sweep_len = val[sjs_pkg::SWEEP_BITS-1:0];
			sjs_pkg::REG_TAP_WINDOW_MS:  tap_window = val[sjs_pkg::WIN_BITS-1:0];
			sjs_pkg::REG_STEP_PERIOD_MS: step_period = val[sjs_pkg::WIN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int taps, input int len, input int win, input int period);
		wait_drained();
		write_reg(sjs_pkg::REG_TAPS_TO_SWEEP, cfg_data_t'(taps));
		write_reg(sjs_pkg::REG_SWEEP_LENGTH, cfg_data_t'(len));
		write_reg(sjs_pkg::REG_TAP_WINDOW_MS, cfg_data_t'(win));
		write_reg(sjs_pkg::REG_STEP_PERIOD_MS, cfg_data_t'(period));
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		key_down = 1'b0;
		tap_cnt = '0;
		dir_ccw = 1'b0;
		sweep_cnt = '0;
		coil_phase = '0;
		tap_tmr = '0;
		step_tmr = '0;
		coil_now = '0;
		thr_taps = sjs_pkg::TAPS_TO_SWEEP_RST;
		sweep_len = sjs_pkg::SWEEP_LENGTH_RST;
		tap_window = sjs_pkg::TAP_WINDOW_MS_RST;
		step_period = sjs_pkg::STEP_PERIOD_MS_RST;
		send_idle_pct = 13;
		recv_idle_pct = 56;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every key combination, three taps into a sweep, one tap out
		add_poll(1'b0, 1'b0, 1'b0);
		add_poll(1'b0, 1'b0, 1'b1);
		add_poll(1'b1, 1'b0, 1'b1);
		add_poll(1'b1, 1'b1, 1'b1);
		add_poll(1'b0, 1'b1, 1'b1);
		add_poll(1'b0, 1'b1, 1'b0);
		add_poll(1'b1, 1'b1, 1'b0);
		add_poll(1'b1, 1'b0, 1'b0);
		add_poll(1'b0, 1'b0, 1'b0);
		add_poll(1'b1, 1'b0, 1'b0);
		add_poll(1'b0, 1'b0, 1'b1);
		add_poll(1'b0, 1'b1, 1'b0);
		add_poll(1'b0, 1'b0, 1'b0);
		repeat (10) add_poll(1'b0, 1'b0, 1'b1);
		add_poll(1'b1, 1'b0, 1'b0);
		add_poll(1'b0, 1'b0, 1'b0);

		set_regs(2, 5, 30, 2);
		add_moves(80);
		// zero threshold sweeps for good, zero periods step every poll
		set_regs(0, 0, 0, 0);
		add_moves(80);

		send_idle_pct = 56;
		recv_idle_pct = 13;
		// wide window never closes, so a long tap burst wraps the tap counter
		set_regs(63, 254, 65535, 65535);
		repeat (66) begin
			add_poll(1'b1, 1'b0, 1'b0);
			add_poll(1'b0, 1'b0, 1'b0);
		end
		add_moves(40);
		set_regs(1, 255, 8, 0);
		add_moves(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_regs(3, 3, 15, 1);
		hold_req = hold_req + 1;
		add_moves(80);
		set_regs($urandom_range(1, 6), $urandom_range(0, 20), $urandom_range(5, 60),
			$urandom_range(0, 4));
		add_moves(80);

		wait_drained();
		repeat (4) @(posedge clk);
		if (drive_q.size() != 0) errors++;
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
